// ===== design/pld_pkg.sv =====
// shared constants and types of the pairwise l1 distance kernel
// no dependencies; used by every module of the block
package pld_pkg;

  // table geometry
  localparam int unsigned MAX_ITEMS    = 256;
  localparam int unsigned MAX_FEATURES = 64;
  localparam int unsigned ITEM_W       = $clog2(MAX_ITEMS);
  localparam int unsigned FEAT_W       = $clog2(MAX_FEATURES);
  localparam int unsigned ADDR_W       = ITEM_W + FEAT_W;
  localparam int unsigned DEPTH        = MAX_ITEMS * MAX_FEATURES;

  // element and arithmetic widths
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned SUM_W     = DATA_W + FEAT_W;
  localparam int unsigned REM_W     = CNT_W + 1;
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS + 1);

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_FEATURE_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] FC_RESET = CNT_W'(64);

  // request opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // divider handshake
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== design/pairwise_l1_distance_kernel.sv =====
// Pairwise L1 distance kernel. A load request (op 0) writes one signed Q8.8
// element into the feature table. A query request (op 1) reads the two item
// vectors one feature pair per cycle from the dual-read table, sums the
// absolute differences exactly and divides once by the feature count with a
// bit-serial divider; n features are in use (n from 1 to 64), read in a
// single table pass and divided by the 22-step divider. A diagonal query
// (diagonal_rule set, equal ids) returns noise. The next request is taken
// once the result sits in the output register. The table has no reset; only
// written entries may be queried. feature_count is written over the APB port
// at byte address 0.
// depends on pld_pkg, pld_store and pld_div
module pairwise_l1_distance_kernel import pld_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // request channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     op_i,
  input  logic [ITEM_W-1:0]        item_a_i,
  input  logic [ITEM_W-1:0]        item_b_i,
  input  logic [FEAT_W-1:0]        feature_index_i,
  input  logic signed [DATA_W-1:0] feature_value_i,
  input  logic [DATA_W-1:0]        noise_i,
  input  logic                     diagonal_rule_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [DATA_W-1:0]        distance_o,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DIV, S_HOLD} state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  fc_q;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  issue_q;
  logic              v1_q, v2_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] distance_q;
  logic [DATA_W-1:0] result_q;
  logic [ITEM_W-1:0] item_a_q, item_b_q;
  logic [SUM_W-1:0]  sum_q;
  logic [DATA_W-1:0] absdiff_q, absdiff_d;
  logic              in_acc, is_query, is_diag, issue, div_start, out_free;
  logic              out_load;
  logic [DATA_W-1:0] rd_a, rd_b;
  logic [DATA_W-1:0] quotient;
  div_status_t       div_st;
  logic signed [DATA_W:0] diff;
  logic              cfg_wr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FEATURE_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= FC_RESET;
    end else if (cfg_wr) begin
      fc_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_FEATURE_COUNT) ? {{(PDATA_W-CNT_W){1'b0}}, fc_q} : '0;

  // clamp feature count to the usable range
  always_comb begin
    n_eff = fc_q;
    if (fc_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (fc_q > CNT_W'(MAX_FEATURES)) begin
      n_eff = CNT_W'(MAX_FEATURES);
    end
  end

  // request decode
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_query   = in_acc && (op_i == OP_QUERY);
  assign is_diag    = diagonal_rule_i && (item_a_i == item_b_i);
  assign issue      = (state_q == S_RUN) && (issue_q < n_eff);
  assign div_start  = (state_q == S_RUN) && !issue && !v1_q && !v2_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = (state_q == S_HOLD) && out_free;

  // feature table
  pld_store u_store (
    .clk_i       (clk_i),
    .wr_en_i     (in_acc && (op_i == OP_LOAD)),
    .wr_addr_i   ({item_a_i, feature_index_i}),
    .wr_data_i   (feature_value_i),
    .rd_en_i     (issue),
    .rd_addr_a_i ({item_a_q, issue_q[FEAT_W-1:0]}),
    .rd_addr_b_i ({item_b_q, issue_q[FEAT_W-1:0]}),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b)
  );

  // absolute difference of one feature pair
  always_comb begin
    diff      = $signed({rd_a[DATA_W-1], rd_a}) - $signed({rd_b[DATA_W-1], rd_b});
    absdiff_d = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
  end

  // single division of the sum
  pld_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (n_eff),
    .status_o   (div_st),
    .quotient_o (quotient)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_q     <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      distance_q  <= '0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      // load a finished result, clear on acceptance
      if (out_load) begin
        out_valid_q <= 1'b1;
        distance_q  <= result_q;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          issue_q <= '0;
          if (is_query) begin
            state_q <= is_diag ? S_HOLD : S_RUN;
          end
        end
        S_RUN: begin
          if (issue) begin
            issue_q <= issue_q + CNT_W'(1);
          end else if (div_start) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            state_q <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // query payload and accumulation
  always_ff @(posedge clk_i) begin
    if (is_query) begin
      item_a_q <= item_a_i;
      item_b_q <= item_b_i;
      sum_q    <= '0;
      result_q <= noise_i;
    end else begin
      if (v1_q) begin
        absdiff_q <= absdiff_d;
      end
      if (v2_q) begin
        sum_q <= sum_q + {{(SUM_W-DATA_W){1'b0}}, absdiff_q};
      end
      if ((state_q == S_DIV) && div_st.done) begin
        result_q <= quotient;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = distance_q;

  // the divider starts only after the pipeline has drained
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !v1_q && !v2_q && !div_st.busy)
    else $error("divider started with pipeline busy");

  // reads never run past the feature count
  a_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> issue_q <= n_eff)
    else $error("feature reads beyond count");

  // a diagonal query goes straight to the output stage
  a_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_query && is_diag) |=> (state_q == S_HOLD) && (result_q == $past(noise_i)))
    else $error("diagonal query mishandled");

  // a pending result is not overwritten
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(distance_q))
    else $error("pending result lost");

  // divider completion only while waiting for it
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == S_DIV))
    else $error("unexpected divider completion");

endmodule

// ===== design/pld_store.sv =====
// feature table: one write port and two registered read ports
// depends on pld_pkg for geometry and element width
module pld_store import pld_pkg::*; (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_a_i,
  input  logic [ADDR_W-1:0] rd_addr_b_i,
  output logic [DATA_W-1:0] rd_data_a_o,
  output logic [DATA_W-1:0] rd_data_b_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read ports, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_a_o <= mem[rd_addr_a_i];
      rd_data_b_o <= mem[rd_addr_b_i];
    end
  end

endmodule

// ===== design/pld_div.sv =====
// bit-serial restoring divider for the sum of absolute differences
// depends on pld_pkg for widths and the status struct
module pld_div import pld_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  dividend_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output div_status_t       status_o,
  output logic [DATA_W-1:0] quotient_o
);

  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [REM_W-1:0]  rem_sh;
  logic              ge;

  // one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q[REM_W-2:0], quo_q[SUM_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    quo_d  = {quo_q[SUM_W-2:0], ge};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= !start_i && busy_q && (step_q == STEP_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(DIV_STEPS);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q[DATA_W-1:0];

endmodule

// ===== tb/sv/pairwise_l1_distance_kernel_tb.sv =====
// self-checking testbench for the pairwise l1 distance kernel: loads feature vectors,
// queries pair distances under several feature counts and checks every returned distance
// depends on pld_pkg and the pairwise_l1_distance_kernel top level
module pairwise_l1_distance_kernel_tb;
  import pld_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned IDLE_PCT     = 31;

  // one request as offered on the input channel
  typedef struct packed {
    logic                     op;
    logic [ITEM_W-1:0]        item_a;
    logic [ITEM_W-1:0]        item_b;
    logic [FEAT_W-1:0]        feature_index;
    logic signed [DATA_W-1:0] feature_value;
    logic [DATA_W-1:0]        noise;
    logic                     diagonal_rule;
  } request_t;

  // expected distance with the query that caused it
  typedef struct packed {
    logic [DATA_W-1:0] distance;
    request_t          query;
  } pending_distance_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     op_i = OP_LOAD;
  logic [ITEM_W-1:0]        item_a_i = '0;
  logic [ITEM_W-1:0]        item_b_i = '0;
  logic [FEAT_W-1:0]        feature_index_i = '0;
  logic signed [DATA_W-1:0] feature_value_i = '0;
  logic [DATA_W-1:0]        noise_i = '0;
  logic                     diagonal_rule_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [DATA_W-1:0]        distance_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = '0;
  logic [PDATA_W-1:0]       pwdata = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;

  pairwise_l1_distance_kernel dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .op_i, .item_a_i, .item_b_i, .feature_index_i, .feature_value_i, .noise_i,
    .diagonal_rule_i,
    .out_valid_o, .out_ready_i, .distance_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // predictor state: feature table mirror and feature count register
  logic [DATA_W-1:0] tbl_mem [DEPTH];
  logic [CNT_W-1:0]  fc_reg = FC_RESET;

  // stimulus bookkeeping: written entries and length of written prefix per item
  bit          gen_written [DEPTH];
  int unsigned gen_filled [MAX_ITEMS];
  int unsigned gen_n;

  request_t          request_q [$];
  pending_distance_t distance_q [$];
  request_t          drv_req;

  bit          steady = 1'b0;
  bit          hold_start = 1'b0;
  int unsigned hold_left = 0;
  wire         rx_hold = (hold_left != 0);

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned n_loads = 0;
  int unsigned n_queries = 0;
  int unsigned n_diag = 0;
  int unsigned n_checked = 0;
  int unsigned n_settings = 0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pairwise_l1_distance_kernel test failed");
      $finish;
    end
  end

  // features in use for a register value
  function automatic int unsigned eff_features(logic [CNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_FEATURES) return MAX_FEATURES;
    return 32'(v);
  endfunction

  // mean absolute difference of two stored vectors, or noise on the diagonal
  function automatic logic [DATA_W-1:0] predict_distance(request_t r);
    int unsigned n;
    int unsigned sum;
    int          d;
    logic signed [DATA_W-1:0] ea;
    logic signed [DATA_W-1:0] eb;
    if (r.diagonal_rule && r.item_a == r.item_b) return r.noise;
    n = eff_features(fc_reg);
    sum = 0;
    for (int unsigned z = 0; z < n; z++) begin
      ea = tbl_mem[{r.item_a, FEAT_W'(z)}];
      eb = tbl_mem[{r.item_b, FEAT_W'(z)}];
      d = int'(ea) - int'(eb);
      sum += (d < 0) ? -d : d;
    end
    return DATA_W'(sum / n);
  endfunction

  // update the mirror on an accepted load, queue the distance of a query
  function automatic void record_request(request_t r);
    pending_distance_t e;
    if (r.op == OP_LOAD) begin
      tbl_mem[{r.item_a, r.feature_index}] = r.feature_value;
    end else begin
      e.distance = predict_distance(r);
      e.query = r;
      distance_q.push_back(e);
    end
  endfunction

  // compare a returned distance with the oldest expectation
  function automatic void check_distance(logic [DATA_W-1:0] got);
    pending_distance_t e;
    n_checked++;
    if (distance_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected distance %0d with no query outstanding", got);
    end else begin
      e = distance_q.pop_front();
      if (got !== e.distance) begin
        mismatches++;
        if (mismatches <= 10)
          $display("distance mismatch: items %0d,%0d diag %0b count %0d: expected %0d got %0d",
                   e.query.item_a, e.query.item_b, e.query.diagonal_rule, fc_reg,
                   e.distance, got);
      end
    end
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) record_request(drv_req);
      if (!in_valid_i || in_ready_o) begin
        if (request_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          drv_req = request_q.pop_front();
          op_i            <= drv_req.op;
          item_a_i        <= drv_req.item_a;
          item_b_i        <= drv_req.item_b;
          feature_index_i <= drv_req.feature_index;
          feature_value_i <= drv_req.feature_value;
          noise_i         <= drv_req.noise;
          diagonal_rule_i <= drv_req.diagonal_rule;
          in_valid_i      <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_distance(distance_o);
      out_ready_i <= !rx_hold && (steady || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // write the feature count register over apb
  task automatic write_feature_count(logic [CNT_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_FEATURE_COUNT, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    fc_reg = value;
    gen_n = eff_features(value);
    n_settings++;
  endtask

  // wait until every request is taken and every distance returned
  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_q.size() != 0 || in_valid_i || distance_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic void push_load(int unsigned id, int unsigned idx, logic [DATA_W-1:0] val);
    request_t r;
    r.op            = OP_LOAD;
    r.item_a        = ITEM_W'(id);
    r.item_b        = ITEM_W'($urandom);
    r.feature_index = FEAT_W'(idx);
    r.feature_value = val;
    r.noise         = DATA_W'($urandom);
    r.diagonal_rule = 1'($urandom);
    request_q.push_back(r);
    n_loads++;
    gen_written[{r.item_a, r.feature_index}] = 1'b1;
    while (gen_filled[id] < MAX_FEATURES && gen_written[{r.item_a, FEAT_W'(gen_filled[id])}])
      gen_filled[id]++;
  endfunction

  function automatic void push_query(int unsigned a, int unsigned b, logic [DATA_W-1:0] nz,
                                     logic diag);
    request_t r;
    r.op            = OP_QUERY;
    r.item_a        = ITEM_W'(a);
    r.item_b        = ITEM_W'(b);
    r.feature_index = FEAT_W'($urandom);
    r.feature_value = DATA_W'($urandom);
    r.noise         = nz;
    r.diagonal_rule = diag;
    request_q.push_back(r);
    n_queries++;
    if (diag && a == b) n_diag++;
  endfunction

  // write the missing prefix of one item so it can be queried
  function automatic void fill_item(int unsigned id);
    while (gen_filled[id] < gen_n)
      push_load(id, gen_filled[id], DATA_W'($urandom));
  endfunction

  // random item whose first gen_n features are written
  function automatic int unsigned pick_ready();
    int unsigned ids [$];
    for (int unsigned i = 0; i < MAX_ITEMS; i++)
      if (gen_filled[i] >= gen_n) ids.push_back(i);
    return ids[$urandom_range(ids.size() - 1)];
  endfunction

  // any ready item, or item 0 when none is ready yet
  function automatic int unsigned pick_ready_or_any();
    for (int unsigned i = 0; i < MAX_ITEMS; i++)
      if (gen_filled[i] >= gen_n) return pick_ready();
    return 0;
  endfunction

  // random mix of loads and queries, non-diagonal queries only on fully written vectors
  function automatic void random_mix(int unsigned count);
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 28) begin
        push_load(pick_ready(), $urandom_range(gen_n - 1), DATA_W'($urandom));
      end else if (r < 40) begin
        push_load($urandom_range(MAX_ITEMS - 1), $urandom_range(MAX_FEATURES - 1),
                  DATA_W'($urandom));
      end else if (r < 48) begin
        r = $urandom_range(MAX_ITEMS - 1);
        push_query(r, r, DATA_W'($urandom), 1'b1);
      end else begin
        push_query(pick_ready(), pick_ready(), DATA_W'($urandom), 1'($urandom));
      end
    end
  endfunction

  // one configuration phase: drain, set count, prepare vectors, random traffic, optional hold-off
  task automatic run_phase(logic [CNT_W-1:0] count, int unsigned fresh, int unsigned items,
                           bit stall, bit no_idle);
    wait_drained();
    write_feature_count(count);
    @(negedge clk_i);
    steady = no_idle;
    repeat (fresh) fill_item($urandom_range(MAX_ITEMS - 1));
    fill_item(pick_ready_or_any());
    random_mix(items);
    if (stall) begin
      hold_start = 1'b1;
      @(negedge clk_i);
      hold_start = 1'b0;
    end
    wait_drained();
    steady = 1'b0;
  endtask

  // stimulus sequence
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    // directed: single feature in use, extreme elements, diagonal cases
    write_feature_count(CNT_W'(0));
    @(negedge clk_i);
    push_load(0, 0, 16'h7fff);
    push_load(255, 0, 16'h8000);
    push_load(1, 0, 16'h8000);
    push_load(3, 0, 16'hffff);
    push_load(2, 63, 16'h0000);
    push_query(0, 255, 16'h0000, 1'b0);
    push_query(255, 0, 16'hffff, 1'b0);
    push_query(0, 0, 16'h1234, 1'b0);
    push_query(0, 0, 16'hffff, 1'b1);
    push_query(200, 200, 16'h0000, 1'b1);
    push_query(0, 255, 16'habcd, 1'b1);
    push_query(255, 1, 16'h5555, 1'b0);
    push_query(3, 1, 16'haaaa, 1'b0);
    push_query(1, 3, 16'h0001, 1'b0);

    // random phases over several feature counts
    run_phase(CNT_W'(127), 3, 60, 1'b0, 1'b0);
    run_phase(CNT_W'(5),   2, 85, 1'b1, 1'b0);
    run_phase(CNT_W'(1),   2, 85, 1'b0, 1'b0);
    run_phase(CNT_W'(64),  1, 70, 1'b0, 1'b1);
    run_phase(CNT_W'(33),  1, 70, 1'b0, 1'b0);
    run_phase(CNT_W'(2),   2, 85, 1'b0, 1'b0);
    run_phase(CNT_W'(12),  2, 85, 1'b0, 1'b0);
    run_phase(CNT_W'(0),   2, 70, 1'b1, 1'b0);
    wait_drained();

    $display("sent %0d loads and %0d queries (%0d diagonal), checked %0d distances",
             n_loads, n_queries, n_diag, n_checked);
    $display("feature count written %0d times, 0 and 127 included; %0d mismatches",
             n_settings, mismatches);
    if (mismatches == 0) begin
      $display("pairwise_l1_distance_kernel test passed");
    end else begin
      $display("pairwise_l1_distance_kernel test failed");
    end
    $finish;
  end

endmodule
